>>> hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Shared widths, field positions, codes and types of the walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    // Fixed geometry of one table level and of a page.
    localparam int INDEX_BITS  = 9;
    localparam int OFFSET_BITS = 12;

    // Item field widths.
    localparam int VADDR_W = 64;
    localparam int ENTRY_W = 64;
    localparam int PA_W    = 56;
    localparam int PPN_W   = 44;

    // Entry layout: valid flag, user flag and the page number field.
    localparam int ENTRY_VALID_BIT = 0;
    localparam int ENTRY_USER_BIT  = 4;
    localparam int ENTRY_PPN_LSB   = 10;

    // An entry is eight bytes, so the index is scaled by three bit positions.
    localparam int ENTRY_SCALE_BITS = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_PAGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_USER = 2'd1;
    localparam int CFG_DATA_W = PPN_W;

    // Input item modes.
    localparam logic MODE_TRANSLATE = 1'b0;
    localparam logic MODE_RESPONSE  = 1'b1;

    typedef enum logic
    {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        FAULT_NONE    = 2'd0,
        FAULT_RANGE   = 2'd1,
        FAULT_INVALID = 2'd2,
        FAULT_USER    = 2'd3
    } fault_t;

    // Configuration as seen by the walk logic.
    typedef struct packed
    {
        logic [PPN_W-1:0] root_page;
        logic             require_user;
    } ptw_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptw_ifs.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker channels
// Valid/ready channel interfaces for input items, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [ptw_pkg::VADDR_W-1:0]  virt_addr;
    logic [ptw_pkg::ENTRY_W-1:0]  entry_data;

    modport source (output valid, output mode, output virt_addr, output entry_data,
                    input ready);
    modport sink   (input valid, input mode, input virt_addr, input entry_data,
                    output ready);
endinterface

interface ptw_rsp_if;
    logic                      valid;
    logic                      ready;
    ptw_pkg::kind_t            kind;
    logic [ptw_pkg::PA_W-1:0]  read_addr;
    logic [ptw_pkg::PA_W-1:0]  phys_addr;
    ptw_pkg::fault_t           fault;

    modport source (output valid, output kind, output read_addr, output phys_addr,
                    output fault, input ready);
    modport sink   (input valid, input kind, input read_addr, input phys_addr,
                    input fault, output ready);
endinterface

interface ptw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ptw_pkg::CFG_IDX_W-1:0]     index;
    logic [ptw_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sv39_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker
// Multi-level virtual-to-physical translation walker with a valid/ready
// item interface toward the requester and the memory system.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes two kinds of item. With mode 0 it starts a translation
// of virt_addr; with mode 1 it returns the table entry that memory read for
// the last read request. The rsp channel gives at most one item per input
// item: kind 0 is a read request for the entry at read_addr, kind 1 ends the
// translation with phys_addr or a fault code (range, invalid entry, missing
// user bit). A response that arrives with no walk in progress gives nothing,
// and a new translation drops any walk in progress.
// Every item is handled in a single pass: it is registered at acceptance and
// its result is registered once the result register is free. One item per
// cycle is accepted while the receiver does not stall; the full walk time is
// set by the memory round trip of each level. The cfg channel sets the root
// table page (index 0) and the user-check enable (index 1); it is always
// ready. Write it only while idle; the block itself does not enforce this.
// Reset clears the walk state, sets the root page to 0 and enables the user
// check. When the receiver stalls, the result is held, and one more input
// item is still taken into the input register before req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sv39_page_table_walker_unit
#(
    parameter int LEVELS = 3
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ptw_req_if.sink   req,
    ptw_rsp_if.source rsp,
    ptw_cfg_if.sink   cfg
);
    import ptw_pkg::*;

    ptw_cfg_t cfg_state;

    ptw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    ptw_walk_core #(.LEVELS(LEVELS)) u_walk_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_state (cfg_state),
        .req       (req),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ptw_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker configuration registers
// Holds the root table page and the user-check enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_cfg_regs
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ptw_cfg_if.sink          cfg,
    output ptw_pkg::ptw_cfg_t cfg_state
);
    import ptw_pkg::*;

    logic [PPN_W-1:0] root_page_reg;
    logic             require_user_reg;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_page_reg    <= '0;
            require_user_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROOT_PAGE:    root_page_reg    <= cfg.data[PPN_W-1:0];
                REG_REQUIRE_USER: require_user_reg <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    assign cfg_state.root_page    = root_page_reg;
    assign cfg_state.require_user = require_user_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ptw_walk_core.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker core
// Input register, walk state, one-pass step logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_walk_core
#(
    parameter int LEVELS = 3
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  ptw_pkg::ptw_cfg_t cfg_state,
    ptw_req_if.sink           req,
    ptw_rsp_if.source         rsp
);
    import ptw_pkg::*;

    localparam int VA_BITS = LEVELS * INDEX_BITS + OFFSET_BITS;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVELS - 1);

    // Input stage: one item, payload muxed down to the field the mode uses.
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic [ENTRY_W-1:0] s1_data_reg;

    // Walk state.
    logic               busy_reg, busy_next;
    logic [LVL_W-1:0]   walk_level_reg, walk_level_next;
    logic [VA_BITS-1:0] held_vaddr_reg, held_vaddr_next;

    // Result register.
    logic               out_valid_reg;
    kind_t              kind_reg, kind_next;
    logic [PA_W-1:0]    read_addr_reg, read_addr_next;
    logic [PA_W-1:0]    phys_addr_reg, phys_addr_next;
    fault_t             fault_reg, fault_next;
    logic               has_result;

    logic               out_free;
    logic               fire;
    logic               req_take;

    logic               out_of_range;
    logic [PPN_W-1:0]   entry_page;
    logic [LVL_W-1:0]   lower_level;
    logic [INDEX_BITS-1:0] new_top_index;
    logic [INDEX_BITS-1:0] held_index [LEVELS];

    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_take  = req.valid && req.ready;

    // Per-level index fields of the address being walked.
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_index
        assign held_index[g] = held_vaddr_reg[OFFSET_BITS + INDEX_BITS * g +: INDEX_BITS];
    end

    assign out_of_range  = |s1_data_reg[VADDR_W-1:VA_BITS-1];
    assign new_top_index =
        s1_data_reg[OFFSET_BITS + INDEX_BITS * (LEVELS - 1) +: INDEX_BITS];
    assign entry_page    = s1_data_reg[ENTRY_PPN_LSB +: PPN_W];
    assign lower_level   = walk_level_reg - 1'b1;

    always_comb
    begin
        busy_next       = busy_reg;
        walk_level_next = walk_level_reg;
        held_vaddr_next = held_vaddr_reg;
        has_result      = 1'b0;
        kind_next       = KIND_DONE;
        read_addr_next  = '0;
        phys_addr_next  = '0;
        fault_next      = FAULT_NONE;

        if (s1_mode_reg == MODE_TRANSLATE)
        begin
            // A new translation replaces any walk in progress.
            has_result      = 1'b1;
            walk_level_next = TOP_LEVEL;
            if (out_of_range)
            begin
                busy_next  = 1'b0;
                fault_next = FAULT_RANGE;
            end
            else
            begin
                busy_next       = 1'b1;
                held_vaddr_next = s1_data_reg[VA_BITS-1:0];
                kind_next       = KIND_READ;
                read_addr_next  = {cfg_state.root_page, new_top_index,
                                   ENTRY_SCALE_BITS'(0)};
            end
        end
        else if (busy_reg)
        begin
            has_result = 1'b1;
            if (!s1_data_reg[ENTRY_VALID_BIT])
            begin
                busy_next       = 1'b0;
                walk_level_next = TOP_LEVEL;
                fault_next      = FAULT_INVALID;
            end
            else if (walk_level_reg != '0)
            begin
                walk_level_next = lower_level;
                kind_next       = KIND_READ;
                read_addr_next  = {entry_page, held_index[lower_level],
                                   ENTRY_SCALE_BITS'(0)};
            end
            else
            begin
                busy_next       = 1'b0;
                walk_level_next = TOP_LEVEL;
                if (cfg_state.require_user && !s1_data_reg[ENTRY_USER_BIT])
                begin
                    fault_next = FAULT_USER;
                end
                else
                begin
                    phys_addr_next = {entry_page, held_vaddr_reg[OFFSET_BITS-1:0]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            walk_level_reg <= TOP_LEVEL;
            held_vaddr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                busy_reg       <= busy_next;
                walk_level_reg <= walk_level_next;
                held_vaddr_reg <= held_vaddr_next;
                out_valid_reg  <= has_result;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_mode_reg <= req.mode;
            s1_data_reg <= (req.mode == MODE_TRANSLATE) ? req.virt_addr : req.entry_data;
        end
        if (fire && has_result)
        begin
            kind_reg      <= kind_next;
            read_addr_reg <= read_addr_next;
            phys_addr_reg <= phys_addr_next;
            fault_reg     <= fault_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = kind_reg;
    assign rsp.read_addr = read_addr_reg;
    assign rsp.phys_addr = phys_addr_reg;
    assign rsp.fault     = fault_reg;

    a_idle_at_top: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> walk_level_reg == TOP_LEVEL)
        else $error("walker idle but level is not the top level");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_level_reg <= TOP_LEVEL)
        else $error("walk level beyond the table depth");

    a_read_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_READ |-> fault_reg == FAULT_NONE &&
        phys_addr_reg == '0)
        else $error("read request carries a fault or an address");

    a_done_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_DONE |-> read_addr_reg == '0)
        else $error("finished translation carries a read address");

    a_stray_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_mode_reg == MODE_RESPONSE && !busy_reg |=> !out_valid_reg)
        else $error("response while idle produced a result");

endmodule

`default_nettype wire

>>> tb/ptw_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sv39 page table walker result checker
// Watches the input, result and configuration channels, predicts the result
// item, if any, of each accepted input item and compares it field by field.
// ----------------------------------------------------------------------------

module ptw_walk_checker
#(
    parameter int LEVELS = 3
)
(
    input  logic clk,
    input  logic rst_n,
    ptw_req_if   req,
    ptw_rsp_if   rsp,
    ptw_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    import ptw_pkg::*;

    localparam int VA_BITS = LEVELS * INDEX_BITS + OFFSET_BITS;

    typedef struct
    {
        kind_t           kind;
        logic [PA_W-1:0] read_addr;
        logic [PA_W-1:0] phys_addr;
        fault_t          fault;
    } walk_result_t;

    walk_result_t       expected_results[$];

    // Shadow of the configuration registers and of the walk state.
    logic [PPN_W-1:0]   root_page;
    logic               require_user;
    logic               walk_busy;
    int                 walk_level;
    logic [VA_BITS-1:0] held_va;

    // Byte address of the entry that indexes va at the given level of a table.
    function automatic logic [PA_W-1:0] entry_address(input logic [PPN_W-1:0] page,
                                                      input int level,
                                                      input logic [VA_BITS-1:0] va);
        logic [INDEX_BITS-1:0] idx;
        idx = INDEX_BITS'(va >> (OFFSET_BITS + INDEX_BITS * level));
        return (PA_W'(page) << OFFSET_BITS) + (PA_W'(idx) << ENTRY_SCALE_BITS);
    endfunction

    // Advances the walk state by one input item; returns 1 when it gives a result.
    function automatic bit predict_walk_step(input logic mode,
                                             input logic [VADDR_W-1:0] va,
                                             input logic [ENTRY_W-1:0] pte,
                                             output walk_result_t res);
        logic [PPN_W-1:0] next_page;
        res.kind      = KIND_DONE;
        res.read_addr = '0;
        res.phys_addr = '0;
        res.fault     = FAULT_NONE;
        if (mode == MODE_TRANSLATE)
        begin
            // A new translation always restarts at the top level.
            walk_level = LEVELS - 1;
            if (va >= (64'd1 << (VA_BITS - 1)))
            begin
                walk_busy = 1'b0;
                res.fault = FAULT_RANGE;
                return 1'b1;
            end
            walk_busy     = 1'b1;
            held_va       = VA_BITS'(va);
            res.kind      = KIND_READ;
            res.read_addr = entry_address(root_page, walk_level, held_va);
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        next_page = pte[ENTRY_PPN_LSB +: PPN_W];
        if (!pte[ENTRY_VALID_BIT])
        begin
            walk_busy  = 1'b0;
            walk_level = LEVELS - 1;
            res.fault  = FAULT_INVALID;
            return 1'b1;
        end
        if (walk_level > 0)
        begin
            walk_level--;
            res.kind      = KIND_READ;
            res.read_addr = entry_address(next_page, walk_level, held_va);
            return 1'b1;
        end
        walk_busy  = 1'b0;
        walk_level = LEVELS - 1;
        if (require_user && !pte[ENTRY_USER_BIT])
            res.fault = FAULT_USER;
        else
            res.phys_addr = (PA_W'(next_page) << OFFSET_BITS) |
                            PA_W'(held_va[OFFSET_BITS-1:0]);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t oldest;
        walk_result_t predicted;
        if (!rst_n)
        begin
            root_page    = '0;
            require_user = 1'b1;
            walk_busy    = 1'b0;
            walk_level   = LEVELS - 1;
            held_va      = '0;
            fail_count   = 0;
            expected_results.delete();
        end
        else
        begin
            // Results are checked before the item of this edge is predicted, since
            // a result can only belong to an earlier item.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d read_addr %h phys_addr %h fault %0d",
                           rsp.kind, rsp.read_addr, rsp.phys_addr, rsp.fault);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (rsp.kind !== oldest.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", oldest.kind, rsp.kind);
                        fail_count++;
                    end
                    if (rsp.read_addr !== oldest.read_addr)
                    begin
                        $error("read_addr: expected %h, actual %h",
                               oldest.read_addr, rsp.read_addr);
                        fail_count++;
                    end
                    if (rsp.phys_addr !== oldest.phys_addr)
                    begin
                        $error("phys_addr: expected %h, actual %h",
                               oldest.phys_addr, rsp.phys_addr);
                        fail_count++;
                    end
                    if (rsp.fault !== oldest.fault)
                    begin
                        $error("fault: expected %0d, actual %0d", oldest.fault, rsp.fault);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (predict_walk_step(req.mode, req.virt_addr, req.entry_data, predicted))
                    expected_results.push_back(predicted);
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_ROOT_PAGE)
                    root_page = cfg.data[PPN_W-1:0];
                else if (cfg.index == REG_REQUIRE_USER)
                    require_user = cfg.data[0];
            end
        end
        pending <= expected_results.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sv39 page table walker testbench
// Drives translations and table entries into the walker, stalls both sides at
// random and lets the checker compare every result item with its prediction.
// ----------------------------------------------------------------------------

module testbench;

    import ptw_pkg::*;

    // The walker registers each item and its result, so once the last expected
    // result is back and the settling wait is over, no item is left in flight.
    localparam int SETTLE_CYCLES   = 8;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int PHASES          = 5;
    localparam int PHASE_ITEMS     = 345;
    localparam int IDLE_PERCENT    = 36;

    localparam logic [VADDR_W-1:0] VA_LIMIT  = 64'd1 << 38;
    localparam logic [ENTRY_W-1:0] ALL_ONES  = '1;
    localparam logic [PPN_W-1:0]   PAGE_MAX  = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending_results;
    int item_count    = 0;
    bit calm          = 1'b0;   // no idling on either side while set
    bit hold_results  = 1'b0;   // asks the receiver for one long stall

    ptw_req_if req();
    ptw_rsp_if rsp();
    ptw_cfg_if cfg();

    sv39_page_table_walker_unit #(.LEVELS(3)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    ptw_walk_checker #(.LEVELS(3)) i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // Offers one input item after a random number of idle cycles and returns at
    // the edge where it is accepted. Valid is left high, so back-to-back items
    // never lower and raise it within the same time step.
    task automatic send_item(input logic mode, input logic [VADDR_W-1:0] va,
                             input logic [ENTRY_W-1:0] pte);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.mode       <= mode;
        req.virt_addr  <= va;
        req.entry_data <= pte;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        item_count++;
    endtask

    // Stops offering and waits until every expected result has come back, then
    // lets the block settle so that a stray entry still in flight is gone too.
    task automatic drain_results();
        req.valid <= 1'b0;
        // After the next edge the count also holds the result of the last item taken.
        @(posedge clk);
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes both configuration registers; called only after drain_results.
    task automatic set_walk_config(input logic [PPN_W-1:0] root, input logic user_check);
        cfg.valid <= 1'b1;
        cfg.index <= REG_ROOT_PAGE;
        cfg.data  <= root;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.index <= REG_REQUIRE_USER;
        cfg.data  <= CFG_DATA_W'(user_check);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // The receiver accepts results at random, except for one long stall that
    // it counts out itself while the sender keeps offering items.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                rsp.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        logic [VADDR_W-1:0] va;
        logic [ENTRY_W-1:0] pte;
        logic [PPN_W-1:0]   root;
        int                 choice;
        int                 depth;
        int                 phase_end;

        req.valid      <= 1'b0;
        req.mode       <= MODE_TRANSLATE;
        req.virt_addr  <= '0;
        req.entry_data <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= REG_ROOT_PAGE;
        cfg.data       <= '0;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the reset configuration: root page 0 and the
        // user check enabled.

        // Lowest address, then entries with every bit set: valid, user bit and
        // the largest page number, with flag and reserved bits that must be
        // ignored.
        send_item(MODE_TRANSLATE, '0, ALL_ONES);
        send_item(MODE_RESPONSE, ALL_ONES, ALL_ONES);
        send_item(MODE_RESPONSE, ALL_ONES, ALL_ONES);
        send_item(MODE_RESPONSE, ALL_ONES, ALL_ONES);

        // Highest address in range, page 0 at every level, and a leaf without
        // the user bit while the check is on.
        send_item(MODE_TRANSLATE, VA_LIMIT - 1, '0);
        send_item(MODE_RESPONSE, '0, 64'h1);
        send_item(MODE_RESPONSE, '0, 64'h1);
        send_item(MODE_RESPONSE, '0, 64'h1);

        // Out of range: the first address past the limit and the highest one.
        send_item(MODE_TRANSLATE, VA_LIMIT, '0);
        send_item(MODE_TRANSLATE, ALL_ONES, '0);

        // An entry arriving with no walk in progress gives nothing.
        send_item(MODE_RESPONSE, '0, 64'h11);

        // Invalid entry at the top level.
        send_item(MODE_TRANSLATE, 64'h12_3456_789a, '0);
        send_item(MODE_RESPONSE, '0, ALL_ONES - 1);

        // Invalid entry at the middle level.
        send_item(MODE_TRANSLATE, 64'h2a_aaaa_a555, '0);
        send_item(MODE_RESPONSE, '0, 64'h0000_0000_0040_0401);
        send_item(MODE_RESPONSE, '0, 64'h0);

        // Invalid leaf with everything else set.
        send_item(MODE_TRANSLATE, 64'h15_5555_5aaa, '0);
        send_item(MODE_RESPONSE, '0, 64'h1);
        send_item(MODE_RESPONSE, '0, 64'h1);
        send_item(MODE_RESPONSE, '0, ALL_ONES - 1);

        // A new translation in the middle of a walk drops the old one.
        send_item(MODE_TRANSLATE, 64'h3f_ffff_f000, '0);
        send_item(MODE_RESPONSE, '0, 64'h401);
        send_item(MODE_TRANSLATE, 64'h00_4020_1fff, '0);
        send_item(MODE_RESPONSE, '0, 64'h801);
        send_item(MODE_RESPONSE, '0, 64'hc01);
        send_item(MODE_RESPONSE, '0, 64'h1011);

        // Random part, in phases with different configurations. Each phase
        // starts only after the walker has given back every result.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            calm = 1'b0;
            root = PPN_W'({$urandom, $urandom});
            case (phase)
                0: set_walk_config(PAGE_MAX, 1'b0);
                1: set_walk_config(root, 1'b1);
                2: set_walk_config('0, 1'b0);
                3: set_walk_config(root, 1'($urandom_range(0, 1)));
                default: set_walk_config(PAGE_MAX, 1'b1);
            endcase
            // One phase with a long result stall so the walker fills up and holds
            // off its input; another with no idling at all.
            if (phase == 1)
                hold_results = 1'b1;
            if (phase == 2)
                calm = 1'b1;

            phase_end = item_count + PHASE_ITEMS;
            while (item_count < phase_end)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 80)
                begin
                    // Mostly complete walks; some are cut short so that the next
                    // translation lands in the middle of a walk.
                    depth = (choice < 70) ? 3 : $urandom_range(0, 2);
                    va = {$urandom, $urandom} & (VA_LIMIT - 1);
                    send_item(MODE_TRANSLATE, va, {$urandom, $urandom});
                    for (int lvl = 0; lvl < depth; lvl++)
                    begin
                        pte = {$urandom, $urandom};
                        pte[ENTRY_VALID_BIT] = ($urandom_range(0, 99) < 92);
                        if (lvl == 2)
                            pte[ENTRY_USER_BIT] = ($urandom_range(0, 99) < 80);
                        send_item(MODE_RESPONSE, {$urandom, $urandom}, pte);
                        if (!pte[ENTRY_VALID_BIT])
                            break;
                    end
                end
                else if (choice < 88)
                begin
                    // Out of range, with one of the high bits surely set.
                    va = {$urandom, $urandom};
                    va[$urandom_range(38, 63)] = 1'b1;
                    send_item(MODE_TRANSLATE, va, {$urandom, $urandom});
                end
                else if (choice < 94)
                begin
                    send_item(MODE_RESPONSE, {$urandom, $urandom}, {$urandom, $urandom});
                end
                else
                begin
                    send_item(1'($urandom_range(0, 1)), {$urandom, $urandom},
                              {$urandom, $urandom});
                end
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
